// ----- rtl/lrc_pkg.sv -----
// Shared types and constants for the line rasterizer with clipping.
// Used by every module in rtl/; depends on nothing else.
package lrc_pkg;

    // Fixed widths of the coordinate, length, error, surface, color and config index fields.
    localparam int COORD_BITS    = 16;
    localparam int LEN_BITS      = COORD_BITS + 1;
    localparam int ERR_BITS      = COORD_BITS + 3;
    localparam int DIM_BITS      = 13;
    localparam int COLOR_BITS    = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int MAX_DIM       = 4096;

    // Command codes carried in the action field.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_HEIGHT = 2'd1;

    // Reset value of both surface dimensions.
    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1024);

    // Clip limit; larger register values saturate to this.
    localparam logic [DIM_BITS-1:0] DIM_LIMIT = DIM_BITS'(MAX_DIM);

    // How the walker advances the current point.
    typedef enum logic [2:0] {
        MODE_VSPAN  = 3'd0,
        MODE_HSPAN  = 3'd1,
        MODE_XMAJOR = 3'd2,
        MODE_YMAJOR = 3'd3,
        MODE_DIAG   = 3'd4
    } lrc_mode_t;

    // One command word.
    typedef struct packed {
        logic                         action;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0]        line_color;
    } lrc_in_t;

    // One pixel word.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0]        pixel_color;
        logic                         write_enable;
        logic                         last_pixel;
    } lrc_out_t;

    // Walker state loaded by a start command.
    typedef struct packed {
        lrc_mode_t                    mode;
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [ERR_BITS-1:0]   err;
        logic signed [ERR_BITS-1:0]   err_dec;
        logic signed [ERR_BITS-1:0]   err_inc;
        logic [LEN_BITS-1:0]          left;
        logic                         minor_dir;
    } lrc_line_t;

endpackage

// ----- rtl/lrc_setup.sv -----
// Line setup: turns a start command into the initial walker state.
// Depends on lrc_pkg.
module lrc_setup (
    input  lrc_pkg::lrc_in_t   cmd,
    output lrc_pkg::lrc_line_t line
);

    logic signed [lrc_pkg::COORD_BITS-1:0] sx, sy, ex, ey;
    logic signed [lrc_pkg::LEN_BITS-1:0]   diff_x, diff_y;
    logic [lrc_pkg::LEN_BITS-1:0]          xlen, ylen;
    logic                                  x_eq, y_eq, x_gt, y_gt;
    logic signed [lrc_pkg::COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
    logic signed [lrc_pkg::ERR_BITS-1:0]   x2, y2;

    assign sx = cmd.start_x;
    assign sy = cmd.start_y;
    assign ex = cmd.end_x;
    assign ey = cmd.end_y;

    // Lengths along both axes; they do not depend on endpoint order.
    assign diff_x = {sx[lrc_pkg::COORD_BITS-1], sx} - {ex[lrc_pkg::COORD_BITS-1], ex};
    assign diff_y = {sy[lrc_pkg::COORD_BITS-1], sy} - {ey[lrc_pkg::COORD_BITS-1], ey};
    assign xlen   = diff_x[lrc_pkg::LEN_BITS-1] ? -diff_x : diff_x;
    assign ylen   = diff_y[lrc_pkg::LEN_BITS-1] ? -diff_y : diff_y;
    assign x_eq   = (sx == ex);
    assign y_eq   = (sy == ey);
    assign x_gt   = (sx > ex);
    assign y_gt   = (sy > ey);

    // Endpoints ordered so that y grows from lo to hi.
    assign lo_x = y_gt ? ex : sx;
    assign lo_y = y_gt ? ey : sy;
    assign hi_x = y_gt ? sx : ex;
    assign hi_y = y_gt ? sy : ey;

    assign x2 = {1'b0, xlen, 1'b0};
    assign y2 = {1'b0, ylen, 1'b0};

    // Pick the drawing mode and the starting point.
    always_comb
    begin
        line.err       = '0;
        line.err_dec   = '0;
        line.err_inc   = '0;
        line.minor_dir = 1'b0;
        line.cur_x     = lo_x;
        line.cur_y     = lo_y;
        line.left      = ylen;
        line.mode      = lrc_pkg::MODE_DIAG;
        if (x_eq)
        begin
            line.mode  = lrc_pkg::MODE_VSPAN;
            line.cur_x = sx;
            line.left  = ylen + lrc_pkg::LEN_BITS'(1);
        end
        else if (y_eq)
        begin
            line.mode  = lrc_pkg::MODE_HSPAN;
            line.cur_x = x_gt ? ex : sx;
            line.cur_y = sy;
            line.left  = xlen + lrc_pkg::LEN_BITS'(1);
        end
        else
        begin
            line.minor_dir = x_gt ^ y_gt;
            if (xlen > ylen)
            begin
                // The x-major walk always runs toward larger x.
                line.mode    = lrc_pkg::MODE_XMAJOR;
                line.cur_x   = (x_gt ^ y_gt) ? hi_x : lo_x;
                line.cur_y   = (x_gt ^ y_gt) ? hi_y : lo_y;
                line.left    = xlen;
                line.err     = y2 - {2'b0, xlen};
                line.err_dec = y2 - x2;
                line.err_inc = y2;
            end
            else if (ylen > xlen)
            begin
                line.mode    = lrc_pkg::MODE_YMAJOR;
                line.err     = x2 - {2'b0, ylen};
                line.err_dec = x2 - y2;
                line.err_inc = x2;
            end
        end
    end

endmodule

// ----- rtl/lrc_walker.sv -----
// Line walker: holds the active line, advances it one pixel per step and
// forms the clipped pixel word. Depends on lrc_pkg.
module lrc_walker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           step,
    input  lrc_pkg::lrc_line_t             setup,
    input  logic [lrc_pkg::COLOR_BITS-1:0] color,
    input  logic [lrc_pkg::DIM_BITS-1:0]   width_lim,
    input  logic [lrc_pkg::DIM_BITS-1:0]   height_lim,
    output logic                           active,
    output lrc_pkg::lrc_out_t              pixel
);

    logic                           active_reg, active_next;
    lrc_pkg::lrc_line_t             line_reg, line_next;
    logic [lrc_pkg::COLOR_BITS-1:0] color_reg;
    logic                           last;
    logic                           err_ge;
    logic [lrc_pkg::COORD_BITS-1:0] minor_step;

    assign last       = (line_reg.left <= lrc_pkg::LEN_BITS'(1));
    assign err_ge     = !line_reg.err[lrc_pkg::ERR_BITS-1];
    assign minor_step = line_reg.minor_dir ? '1 : lrc_pkg::COORD_BITS'(1);

    // Load a new line, or advance the current point by one pixel.
    always_comb
    begin
        line_next   = line_reg;
        active_next = active_reg;
        if (load)
        begin
            line_next   = setup;
            active_next = 1'b1;
        end
        else if (step)
        begin
            case (line_reg.mode)
                lrc_pkg::MODE_VSPAN:
                begin
                    line_next.cur_y = line_reg.cur_y + lrc_pkg::COORD_BITS'(1);
                end
                lrc_pkg::MODE_HSPAN:
                begin
                    line_next.cur_x = line_reg.cur_x + lrc_pkg::COORD_BITS'(1);
                end
                lrc_pkg::MODE_XMAJOR:
                begin
                    line_next.cur_x = line_reg.cur_x + lrc_pkg::COORD_BITS'(1);
                    if (err_ge)
                    begin
                        line_next.cur_y = line_reg.cur_y + minor_step;
                        line_next.err   = line_reg.err + line_reg.err_dec;
                    end
                    else
                    begin
                        line_next.err = line_reg.err + line_reg.err_inc;
                    end
                end
                lrc_pkg::MODE_YMAJOR:
                begin
                    line_next.cur_y = line_reg.cur_y + lrc_pkg::COORD_BITS'(1);
                    if (err_ge)
                    begin
                        line_next.cur_x = line_reg.cur_x + minor_step;
                        line_next.err   = line_reg.err + line_reg.err_dec;
                    end
                    else
                    begin
                        line_next.err = line_reg.err + line_reg.err_inc;
                    end
                end
                default:
                begin
                    line_next.cur_x = line_reg.cur_x + minor_step;
                    line_next.cur_y = line_reg.cur_y + lrc_pkg::COORD_BITS'(1);
                end
            endcase
            if (last)
            begin
                line_next.left = '0;
                active_next    = 1'b0;
            end
            else
            begin
                line_next.left = line_reg.left - lrc_pkg::LEN_BITS'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Line payload state.
    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
        if (load)
        begin
            color_reg <= color;
        end
    end

    // Pixel word for the current point, with the clip test.
    always_comb
    begin
        pixel.pixel_x      = line_reg.cur_x;
        pixel.pixel_y      = line_reg.cur_y;
        pixel.pixel_color  = color_reg;
        pixel.last_pixel   = last;
        pixel.write_enable =
            !line_reg.cur_x[lrc_pkg::COORD_BITS-1] &&
            !line_reg.cur_y[lrc_pkg::COORD_BITS-1] &&
            (line_reg.cur_x < {{(lrc_pkg::COORD_BITS-lrc_pkg::DIM_BITS){1'b0}}, width_lim}) &&
            (line_reg.cur_y < {{(lrc_pkg::COORD_BITS-lrc_pkg::DIM_BITS){1'b0}}, height_lim});
    end

    assign active = active_reg;

endmodule

// ----- rtl/line_rasterizer_with_clip.sv -----
// Line rasterizer with surface clipping: top level with the command and pixel
// registers and the surface size registers. Depends on lrc_pkg, lrc_setup, lrc_walker.
//
// A start word loads two endpoints and a color and produces no pixel; each
// following step word produces one pixel word, in drawing order, with
// write_enable low for pixels outside the surface and last_pixel high on the
// final one. Spans include both endpoints; sloped lines omit the final
// endpoint. Steps with no active line are dropped. The block takes one word
// per clock and gives one pixel per clock while the output register is not
// stalled: a word is held in a command register, the line setup or one
// Bresenham step runs while it sits there, and the pixel then sits in an
// output register until it is taken. Surface size registers are written
// through the cfg channel, which is always ready; indexes other than 0 and 1
// are ignored.
module line_rasterizer_with_clip (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  lrc_pkg::lrc_in_t                   cmd,
    output logic                               pix_valid,
    input  logic                               pix_ready,
    output lrc_pkg::lrc_out_t                  pix,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lrc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lrc_pkg::DIM_BITS-1:0]       cfg_data
);

    logic                          cmd_valid_reg, cmd_valid_next;
    lrc_pkg::lrc_in_t              cmd_reg;
    logic                          pix_valid_reg, pix_valid_next;
    lrc_pkg::lrc_out_t             pix_reg;
    logic [lrc_pkg::DIM_BITS-1:0]  width_reg, width_next;
    logic [lrc_pkg::DIM_BITS-1:0]  height_reg, height_next;
    logic [lrc_pkg::DIM_BITS-1:0]  width_lim, height_lim;
    lrc_pkg::lrc_line_t            setup;
    lrc_pkg::lrc_out_t             pixel;
    logic                          active;
    logic                          out_free;
    logic                          consume;
    logic                          is_start;
    logic                          load;
    logic                          step;

    // Handshake and flow control.
    assign is_start  = (cmd_reg.action == lrc_pkg::ACT_START);
    assign out_free  = !pix_valid_reg || pix_ready;
    assign consume   = cmd_valid_reg && (is_start || !active || out_free);
    assign load      = consume && is_start;
    assign step      = consume && !is_start && active;
    assign cmd_ready = !cmd_valid_reg || consume;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_valid && cmd_ready)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (consume)
        begin
            cmd_valid_next = 1'b0;
        end

        pix_valid_next = pix_valid_reg;
        if (step)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_ready)
        begin
            pix_valid_next = 1'b0;
        end
    end

    // Surface size register writes.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lrc_pkg::CFG_SURFACE_WIDTH:  width_next  = cfg_data;
                lrc_pkg::CFG_SURFACE_HEIGHT: height_next = cfg_data;
                default:
                begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    // Clip limits saturate at the largest supported surface.
    assign width_lim  = (width_reg > lrc_pkg::DIM_LIMIT) ? lrc_pkg::DIM_LIMIT : width_reg;
    assign height_lim = (height_reg > lrc_pkg::DIM_LIMIT) ? lrc_pkg::DIM_LIMIT : height_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            pix_valid_reg <= 1'b0;
            width_reg     <= lrc_pkg::DIM_RESET;
            height_reg    <= lrc_pkg::DIM_RESET;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            pix_valid_reg <= pix_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (step)
        begin
            pix_reg <= pixel;
        end
    end

    lrc_setup u_setup (
        .cmd  (cmd_reg),
        .line (setup)
    );

    lrc_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .step       (step),
        .setup      (setup),
        .color      (cmd_reg.line_color),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .active     (active),
        .pixel      (pixel)
    );

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

// ----- tb/line_rasterizer_with_clip_tb.sv -----
// Self-checking testbench for line_rasterizer_with_clip: directed and random lines
// against a scoreboard with its own line walker. Depends on lrc_pkg and the RTL top.
`timescale 1ns / 100ps

module line_rasterizer_with_clip_tb;

    // Indexes past the two surface registers; writes to them must be ignored.
    localparam logic [lrc_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [lrc_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;
    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_ITEMS   = 55;

    // Tracks the walker state, predicts each pixel word and checks the ones received.
    class pixel_scoreboard;
        lrc_pkg::lrc_out_t                     expected_pixels[$];
        int                                    errors;
        logic [lrc_pkg::DIM_BITS-1:0]          width;
        logic [lrc_pkg::DIM_BITS-1:0]          height;
        bit                                    active;
        lrc_pkg::lrc_mode_t                    mode;
        logic signed [lrc_pkg::COORD_BITS-1:0] cur_x;
        logic signed [lrc_pkg::COORD_BITS-1:0] cur_y;
        int                                    err;
        int                                    major;
        int                                    minor;
        int                                    left;
        bit                                    minor_dir;
        logic [lrc_pkg::COLOR_BITS-1:0]        color;

        function new();
            errors    = 0;
            width     = lrc_pkg::DIM_RESET;
            height    = lrc_pkg::DIM_RESET;
            active    = 1'b0;
            mode      = lrc_pkg::MODE_VSPAN;
            cur_x     = '0;
            cur_y     = '0;
            err       = 0;
            major     = 0;
            minor     = 0;
            left      = 0;
            minor_dir = 1'b0;
            color     = '0;
        endfunction

        function void write_surface(logic [lrc_pkg::CFG_IDX_BITS-1:0] idx,
                                    logic [lrc_pkg::DIM_BITS-1:0] data);
            if (idx == lrc_pkg::CFG_SURFACE_WIDTH)
                width = data;
            else if (idx == lrc_pkg::CFG_SURFACE_HEIGHT)
                height = data;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // A start word loads the walker; a step word yields one pixel while a line is active.
        function void accept_command(lrc_pkg::lrc_in_t w);
            lrc_pkg::lrc_out_t p;
            int sx, sy, ex, ey, t, xlen, ylen, step, dim_w, dim_h;
            if (w.action == lrc_pkg::ACT_START) begin
                sx        = w.start_x;
                sy        = w.start_y;
                ex        = w.end_x;
                ey        = w.end_y;
                color     = w.line_color;
                active    = 1'b1;
                err       = 0;
                major     = 0;
                minor     = 0;
                minor_dir = 1'b0;
                if (sx == ex) begin
                    mode  = lrc_pkg::MODE_VSPAN;
                    cur_x = lrc_pkg::COORD_BITS'(sx);
                    cur_y = lrc_pkg::COORD_BITS'((sy < ey) ? sy : ey);
                    left  = ((sy < ey) ? ey - sy : sy - ey) + 1;
                end
                else if (sy == ey) begin
                    mode  = lrc_pkg::MODE_HSPAN;
                    cur_y = lrc_pkg::COORD_BITS'(sy);
                    cur_x = lrc_pkg::COORD_BITS'((sx < ex) ? sx : ex);
                    left  = ((sx < ex) ? ex - sx : sx - ex) + 1;
                end
                else begin
                    // Sloped lines are ordered so that y grows; y-major and diagonal lines are walked that way.
                    if (sy > ey) begin
                        t = sx; sx = ex; ex = t;
                        t = sy; sy = ey; ey = t;
                    end
                    ylen      = ey - sy;
                    minor_dir = (sx > ex);
                    xlen      = minor_dir ? sx - ex : ex - sx;
                    if (xlen > ylen) begin
                        // X-major walks with x growing, so a leftward line starts at its far end.
                        mode  = lrc_pkg::MODE_XMAJOR;
                        major = xlen;
                        minor = ylen;
                        cur_x = lrc_pkg::COORD_BITS'(minor_dir ? ex : sx);
                        cur_y = lrc_pkg::COORD_BITS'(minor_dir ? ey : sy);
                        left  = xlen;
                        err   = 2 * ylen - xlen;
                    end
                    else begin
                        mode  = (ylen > xlen) ? lrc_pkg::MODE_YMAJOR : lrc_pkg::MODE_DIAG;
                        major = ylen;
                        minor = xlen;
                        cur_x = lrc_pkg::COORD_BITS'(sx);
                        cur_y = lrc_pkg::COORD_BITS'(sy);
                        left  = ylen;
                        if (ylen > xlen)
                            err = 2 * xlen - ylen;
                    end
                end
                return;
            end
            if (!active)
                return;

            // Register values above the limit clip at the limit.
            dim_w = int'((width > lrc_pkg::DIM_LIMIT) ? lrc_pkg::DIM_LIMIT : width);
            dim_h = int'((height > lrc_pkg::DIM_LIMIT) ? lrc_pkg::DIM_LIMIT : height);
            p.pixel_x      = cur_x;
            p.pixel_y      = cur_y;
            p.pixel_color  = color;
            p.write_enable = (cur_x >= 0) && (cur_x < dim_w) && (cur_y >= 0) && (cur_y < dim_h);
            p.last_pixel   = (left <= 1);
            expected_pixels.push_back(p);

            step = minor_dir ? -1 : 1;
            case (mode)
                lrc_pkg::MODE_VSPAN: cur_y = cur_y + lrc_pkg::COORD_BITS'(1);
                lrc_pkg::MODE_HSPAN: cur_x = cur_x + lrc_pkg::COORD_BITS'(1);
                lrc_pkg::MODE_XMAJOR: begin
                    if (err >= 0) begin
                        cur_y = cur_y + lrc_pkg::COORD_BITS'(step);
                        err   = err + 2 * (minor - major);
                    end
                    else begin
                        err = err + 2 * minor;
                    end
                    cur_x = cur_x + lrc_pkg::COORD_BITS'(1);
                end
                lrc_pkg::MODE_YMAJOR: begin
                    if (err >= 0) begin
                        cur_x = cur_x + lrc_pkg::COORD_BITS'(step);
                        err   = err + 2 * (minor - major);
                    end
                    else begin
                        err = err + 2 * minor;
                    end
                    cur_y = cur_y + lrc_pkg::COORD_BITS'(1);
                end
                default: begin
                    cur_x = cur_x + lrc_pkg::COORD_BITS'(step);
                    cur_y = cur_y + lrc_pkg::COORD_BITS'(1);
                end
            endcase
            if (p.last_pixel) begin
                left   = 0;
                active = 1'b0;
            end
            else begin
                left = left - 1;
            end
        endfunction

        function void check_pixel(lrc_pkg::lrc_out_t got);
            lrc_pkg::lrc_out_t exp;
            if (expected_pixels.size() == 0) begin
                $error("pixel word with none expected: x %0d y %0d", got.pixel_x, got.pixel_y);
                errors++;
                return;
            end
            exp = expected_pixels.pop_front();
            if (got.pixel_x !== exp.pixel_x) begin
                $error("pixel_x: expected %0d, got %0d", exp.pixel_x, got.pixel_x);
                errors++;
            end
            if (got.pixel_y !== exp.pixel_y) begin
                $error("pixel_y: expected %0d, got %0d", exp.pixel_y, got.pixel_y);
                errors++;
            end
            if (got.pixel_color !== exp.pixel_color) begin
                $error("pixel_color: expected %h, got %h", exp.pixel_color, got.pixel_color);
                errors++;
            end
            if (got.write_enable !== exp.write_enable) begin
                $error("write_enable: expected %b, got %b", exp.write_enable, got.write_enable);
                errors++;
            end
            if (got.last_pixel !== exp.last_pixel) begin
                $error("last_pixel: expected %b, got %b", exp.last_pixel, got.last_pixel);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cmd_valid;
    logic                             cmd_ready;
    lrc_pkg::lrc_in_t                 cmd;
    logic                             pix_valid;
    logic                             pix_ready;
    lrc_pkg::lrc_out_t                pix;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lrc_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [lrc_pkg::DIM_BITS-1:0]     cfg_data;

    pixel_scoreboard pixels = new();
    bit tx_burst;
    bit rx_burst;
    int stall_left;
    int rx_gap;
    int idle_cycles = 0;
    int surf_w;
    int surf_h;

    line_rasterizer_with_clip DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pixel receiver: after each accepted word, stall for a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pix_ready  <= 1'b0;
            stall_left <= $urandom_range(0, MAX_GAP);
        end
        else if (pix_valid && pix_ready) begin
            rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_gap == 0) begin
                pix_ready <= 1'b1;
            end
            else begin
                stall_left <= rx_gap - 1;
                pix_ready  <= 1'b0;
            end
        end
        else if (!pix_ready) begin
            if (stall_left == 0)
                pix_ready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    // Monitor: feed accepted words to the scoreboard and count cycles without progress.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                pixels.write_surface(cfg_index, cfg_data);
            if (cmd_valid && cmd_ready)
                pixels.accept_command(cmd);
            if (pix_valid && pix_ready)
                pixels.check_pixel(pix);
            if ((cfg_valid && cfg_ready) || (cmd_valid && cmd_ready) || (pix_valid && pix_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("line_rasterizer_with_clip_tb: FAIL");
                $finish;
            end
        end
    end

    // Present one command word after a random gap and wait until it is taken.
    task automatic send_word(lrc_pkg::lrc_in_t w);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic send_start(int sx, int sy, int ex, int ey,
                              logic [lrc_pkg::COLOR_BITS-1:0] color);
        lrc_pkg::lrc_in_t w;
        w.action     = lrc_pkg::ACT_START;
        w.start_x    = sx[lrc_pkg::COORD_BITS-1:0];
        w.start_y    = sy[lrc_pkg::COORD_BITS-1:0];
        w.end_x      = ex[lrc_pkg::COORD_BITS-1:0];
        w.end_y      = ey[lrc_pkg::COORD_BITS-1:0];
        w.line_color = color;
        send_word(w);
    endtask

    // Step words carry random junk in the fields that only a start uses.
    task automatic send_steps(int n);
        lrc_pkg::lrc_in_t w;
        for (int i = 0; i < n; i++) begin
            w.action              = lrc_pkg::ACT_STEP;
            {w.start_x, w.start_y} = $urandom;
            {w.end_x, w.end_y}     = $urandom;
            w.line_color          = $urandom;
            send_word(w);
        end
    endtask

    // Stop sending and wait until every expected pixel has arrived and the pipe is empty.
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pixels.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [lrc_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [lrc_pkg::DIM_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_surface(int w, int h);
        write_reg(lrc_pkg::CFG_SURFACE_WIDTH, w[lrc_pkg::DIM_BITS-1:0]);
        write_reg(lrc_pkg::CFG_SURFACE_HEIGHT, h[lrc_pkg::DIM_BITS-1:0]);
        if ($urandom_range(0, 1) != 0)
            write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      lrc_pkg::DIM_BITS'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
        surf_w = w;
        surf_h = h;
    endtask

    // Coordinates cluster around the origin and the far surface edges, with some full-range.
    function automatic int pick_coord(int dim);
        logic signed [lrc_pkg::COORD_BITS-1:0] raw;
        raw = lrc_pkg::COORD_BITS'($urandom);
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 80)) - 40;
            1: return dim - 24 + int'($urandom_range(0, 48));
            2: return raw;
            default: return int'($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // One start word followed by steps: usually the whole line, sometimes cut short or overrun.
    task automatic random_line(output int used);
        int sx, sy, ex, ey, dx, dy, len, steps;
        logic [lrc_pkg::COLOR_BITS-1:0] color;
        sx = pick_coord(surf_w);
        sy = pick_coord(surf_h);
        dx = int'($urandom_range(0, 48)) - 24;
        dy = int'($urandom_range(0, 48)) - 24;
        case ($urandom_range(0, 5))
            0: dx = 0;
            1: dy = 0;
            2: dy = ($urandom_range(0, 1) != 0) ? dx : -dx;
            5: begin
                dx = pick_coord(surf_w) - sx;
                dy = pick_coord(surf_h) - sy;
            end
            default: ;
        endcase
        ex = clamp_coord(sx + dx);
        ey = clamp_coord(sy + dy);
        dx = (ex > sx) ? ex - sx : sx - ex;
        dy = (ey > sy) ? ey - sy : sy - ey;
        if (sx == ex)
            len = dy + 1;
        else if (sy == ey)
            len = dx + 1;
        else
            len = (dx > dy) ? dx : dy;
        color = $urandom;
        case ($urandom_range(0, 7))
            0: color = '0;
            1: color = '1;
            default: ;
        endcase
        if (len > 64)
            steps = $urandom_range(0, 8);
        else if ($urandom_range(0, 7) == 0)
            steps = $urandom_range(0, len - 1);
        else
            steps = len + (($urandom_range(0, 3) == 0) ? 1 : 0);
        tx_burst = ($urandom_range(0, 5) == 0);
        rx_burst = ($urandom_range(0, 5) == 0);
        send_start(sx, sy, ex, ey, color);
        send_steps(steps);
        used = 1 + steps;
    endtask

    // Main sequence: reset, directed lines, then random phases under several surface sizes.
    initial
    begin
        int used;
        int done;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = lrc_pkg::CFG_SURFACE_WIDTH;
        cfg_data  = '0;
        tx_burst  = 1'b0;
        rx_burst  = 1'b0;
        surf_w    = 1024;
        surf_h    = 1024;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines under the reset surface size.
        send_steps(1);                                          // step with no line
        send_start(5, 5, 5, 5, 32'hFFFF_FFFF);                  // single point
        send_steps(2);
        send_start(-1, 2, -1, 0, 32'h0000_0000);                // vertical, reversed, clipped
        send_steps(3);
        send_start(1025, 7, 1022, 7, 32'h1234_5678);            // horizontal across the right edge
        send_steps(4);
        send_start(3, 0, 0, 1, 32'hA5A5_5A5A);                  // x-major, walked rightward with y decreasing
        send_steps(3);
        send_start(0, 3, 2, 0, 32'h5A5A_A5A5);                  // y-major, reordered, stepping left
        send_steps(3);
        send_start(0, 1023, 1, 1026, 32'h0F0F_F0F0);            // y-major across the bottom edge
        send_steps(3);
        send_start(-32768, 32767, 32767, -32768, 32'hFFFF_FFFF); // full-range diagonal
        send_steps(2);
        send_start(32767, -32768, -32768, -32767, 32'h0000_0001); // replaces the diagonal
        send_steps(1);
        drain();

        // Random phases, each under its own surface size, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_surface(1, 1);
                1: set_surface(4096, 4096);
                2: set_surface(0, 8191);
                3: set_surface(4097, 37);
                4: set_surface($urandom_range(1, 64), $urandom_range(1, 64));
                default: set_surface($urandom_range(1, 8191), $urandom_range(1, 8191));
            endcase
            done = 0;
            while (done < PHASE_ITEMS) begin
                random_line(used);
                done += used;
            end
            drain();
        end

        if (pixels.errors == 0)
            $display("line_rasterizer_with_clip_tb: PASS");
        else
            $display("line_rasterizer_with_clip_tb: FAIL");
        $finish;
    end

endmodule
